// ===== rtl/core/rsms_pkg.sv =====
// Package for the route-switch mute-ramp sequencer.
// Holds widths, phase codes and register indexes; no dependencies.
package rsms_pkg;

	localparam int FIELD_W = 16;
	localparam int GAIN_W = 17;
	localparam int STEP_W = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 17;
	localparam int DIVD_W = 25;
	localparam int DIV_CNT_W = 5;
	localparam int NUM_MASKS = 4;

	localparam logic [GAIN_W-1:0] UNITY_Q16 = 17'h10000;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DOWN = 2'd1;
	localparam logic [1:0] PH_HOLD = 2'd2;
	localparam logic [1:0] PH_UP = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd3;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic [DIVD_W-1:0] divd_t;

	typedef struct packed {
		logic start;
		divd_t dividend;
		step_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		divd_t quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/rsms_if.sv =====
// Channel interfaces for the route-switch mute-ramp sequencer.
// Request, result and configuration channels; uses rsms_pkg widths.
interface rsms_req_if;
	logic valid;
	logic ready;
	logic [rsms_pkg::FIELD_W-1:0] req_enable_mask;
	logic [rsms_pkg::FIELD_W-1:0] req_primary_bypass;
	logic [rsms_pkg::FIELD_W-1:0] req_sfx_bypass;
	logic [rsms_pkg::FIELD_W-1:0] req_noise_source;
	logic mute_request;
	logic [rsms_pkg::GAIN_W-1:0] master_volume;

	modport source (output valid, req_enable_mask, req_primary_bypass, req_sfx_bypass,
		req_noise_source, mute_request, master_volume, input ready);
	modport sink (input valid, req_enable_mask, req_primary_bypass, req_sfx_bypass,
		req_noise_source, mute_request, master_volume, output ready);
endinterface

interface rsms_res_if;
	logic valid;
	logic ready;
	logic [rsms_pkg::FIELD_W-1:0] applied_enable_mask;
	logic [rsms_pkg::FIELD_W-1:0] applied_primary_bypass;
	logic [rsms_pkg::FIELD_W-1:0] applied_sfx_bypass;
	logic [rsms_pkg::FIELD_W-1:0] applied_noise_source;
	logic [rsms_pkg::GAIN_W-1:0] dac_gain;
	logic gain_write;
	logic soft_mute_write;
	logic soft_mute_value;
	logic [1:0] phase;

	modport source (output valid, applied_enable_mask, applied_primary_bypass,
		applied_sfx_bypass, applied_noise_source, dac_gain, gain_write, soft_mute_write,
		soft_mute_value, phase, input ready);
	modport sink (input valid, applied_enable_mask, applied_primary_bypass,
		applied_sfx_bypass, applied_noise_source, dac_gain, gain_write, soft_mute_write,
		soft_mute_value, phase, output ready);
endinterface

interface rsms_cfg_if;
	logic valid;
	logic ready;
	logic [rsms_pkg::CFG_IDX_W-1:0] index;
	logic [rsms_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rsms_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses rsms_pkg for widths and the request/response structs.
module rsms_div (
	input logic clk,
	input logic arst_n,
	input rsms_pkg::div_req_t req,
	output rsms_pkg::div_rsp_t rsp
);
	import rsms_pkg::*;

	localparam logic [DIV_CNT_W-1:0] LAST_BIT = DIV_CNT_W'(DIVD_W - 1);

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	step_t rem_q;
	step_t den_q;
	divd_t quo_q;
	logic [STEP_W:0] trial;
	logic fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? STEP_W'(trial - {1'b0, den_q}) : trial[STEP_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/core/route_switch_mute_ramp_sequencer.sv =====
// Top level of the route-switch mute-ramp sequencer.
// Depends on rsms_pkg, the channel interfaces in rsms_if and the divider rsms_div.
//
// Usage: one beat on req is one control tick with four requested routing masks,
// a mute request and a master volume. For each tick the block returns one beat on
// res with the masks in force, the DAC gain, the write flags and the phase.
// A mask change seen while idle starts a ramp down, then a hold at the floor,
// then a ramp up; the new masks are latched when the ramp reaches the floor.
// Configuration writes on cfg (index 0 ramp down steps, 1 hold steps, 2 ramp up
// steps, 3 write threshold) are always accepted and belong in idle time.
// Steps: the idle state takes a request beat; the prep state sets the ramp
// fraction, forms volume times numerator and starts the bit-serial divider;
// the divide state waits for the quotient; the finish state checks the
// threshold and loads the result register once that register is free.
// req is ready only while no tick is in work, so a new tick is taken only after
// the last one has loaded its result. A stalled res holds its beat and the next
// tick proceeds until its own result needs the result register.
// Reset clears the phase, step count, applied masks, gain history and result
// valid flag, and loads the default configuration.
module route_switch_mute_ramp_sequencer #(
	parameter int MASK_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	rsms_req_if.sink req,
	rsms_res_if.source res,
	rsms_cfg_if.sink cfg
);
	import rsms_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_DIV = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	logic [1:0] state_q;

	step_t ramp_down_q, hold_q, ramp_up_q;
	gain_t thr_q;

	logic [1:0] phase_q;
	step_t step_q;
	logic [NUM_MASKS-1:0][MASK_BITS-1:0] cur_q;
	gain_t last_gain_q;
	logic ever_q;
	logic last_mute_q;

	logic [NUM_MASKS-1:0][FIELD_W-1:0] req_raw_q;
	logic mute_q;
	gain_t vol_q;
	logic [1:0] ph_q;

	logic res_valid_q;
	logic [NUM_MASKS-1:0][FIELD_W-1:0] out_mask_q;
	gain_t out_gain_q;
	logic out_wr_q, out_smw_q, out_smv_q;
	logic [1:0] out_ph_q;

	logic [NUM_MASKS-1:0][MASK_BITS-1:0] req_m;
	logic [NUM_MASKS-1:0][FIELD_W-1:0] cur_out;
	logic differs, start_ramp;
	logic [1:0] ph;
	step_t sc, n, num, den, adv, hold_n, down_n, up_n;
	logic [STEP_W:0] inc;
	logic at_end;
	gain_t vol_sat, gain, diff;
	logic wr, out_free;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Fit each field to the configured mask width both ways.
	always_comb begin
		for (int i = 0; i < NUM_MASKS; i++) begin
			logic [MASK_BITS+FIELD_W-1:0] wide_in, wide_out;
			wide_in = {{MASK_BITS{1'b0}}, req_raw_q[i]};
			wide_out = {{FIELD_W{1'b0}}, cur_q[i]};
			req_m[i] = wide_in[MASK_BITS-1:0];
			cur_out[i] = wide_out[FIELD_W-1:0];
		end
	end

	assign differs = (req_m != cur_q);
	assign start_ramp = (phase_q == PH_IDLE) && differs;
	assign ph = start_ramp ? PH_DOWN : phase_q;
	assign sc = start_ramp ? '0 : step_q;

	assign down_n = (ramp_down_q == '0) ? STEP_W'(1) : ramp_down_q;
	assign hold_n = (hold_q == '0) ? STEP_W'(1) : hold_q;
	assign up_n = (ramp_up_q == '0) ? STEP_W'(1) : ramp_up_q;

	always_comb begin
		case (ph)
			PH_DOWN: n = down_n;
			PH_HOLD: n = hold_n;
			PH_UP: n = up_n;
			default: n = STEP_W'(1);
		endcase
	end

	// Saturate the step at the phase length.
	assign inc = {1'b0, sc} + 1'b1;
	assign adv = (inc > {1'b0, n}) ? n : inc[STEP_W-1:0];
	assign at_end = adv >= n;

	always_comb begin
		case (ph)
			PH_DOWN: begin
				num = n - adv;
				den = n;
			end
			PH_HOLD: begin
				num = '0;
				den = STEP_W'(1);
			end
			PH_UP: begin
				num = adv;
				den = n;
			end
			default: begin
				num = STEP_W'(1);
				den = STEP_W'(1);
			end
		endcase
	end

	assign vol_sat = (vol_q > UNITY_Q16) ? UNITY_Q16 : vol_q;

	assign div_req.start = (state_q == S_PREP);
	assign div_req.dividend = DIVD_W'(vol_sat) * DIVD_W'(num) + DIVD_W'(den >> 1);
	assign div_req.divisor = den;

	rsms_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign gain = mute_q ? '0 : div_rsp.quotient[GAIN_W-1:0];
	assign diff = (gain > last_gain_q) ? gain - last_gain_q : last_gain_q - gain;
	assign wr = !ever_q || (diff > thr_q);
	assign out_free = !res_valid_q || res.ready;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_down_q <= STEP_W'(20);
			hold_q <= STEP_W'(20);
			ramp_up_q <= STEP_W'(30);
			thr_q <= GAIN_W'(66);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_RAMP_DOWN: ramp_down_q <= cfg.data[STEP_W-1:0];
				CFG_HOLD: hold_q <= cfg.data[STEP_W-1:0];
				CFG_RAMP_UP: ramp_up_q <= cfg.data[STEP_W-1:0];
				CFG_THRESHOLD: thr_q <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			step_q <= '0;
			cur_q <= '0;
			last_gain_q <= '0;
			ever_q <= 1'b0;
			last_mute_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					// Commit the phase advance now; only the gain waits on the divider.
					if (at_end) begin
						step_q <= '0;
						case (ph)
							PH_DOWN: begin
								phase_q <= PH_HOLD;
								cur_q <= req_m;
							end
							PH_HOLD: phase_q <= PH_UP;
							PH_UP: phase_q <= PH_IDLE;
							default: phase_q <= PH_IDLE;
						endcase
					end else begin
						step_q <= adv;
						phase_q <= ph;
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						if (wr) begin
							last_gain_q <= gain;
							ever_q <= 1'b1;
						end
						last_mute_q <= mute_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			req_raw_q[0] <= req.req_enable_mask;
			req_raw_q[1] <= req.req_primary_bypass;
			req_raw_q[2] <= req.req_sfx_bypass;
			req_raw_q[3] <= req.req_noise_source;
			mute_q <= req.mute_request;
			vol_q <= req.master_volume;
		end
		if (state_q == S_PREP) begin
			ph_q <= ph;
		end
		if (state_q == S_FIN && out_free) begin
			out_mask_q <= cur_out;
			out_gain_q <= gain;
			out_wr_q <= wr;
			out_smw_q <= mute_q != last_mute_q;
			out_smv_q <= mute_q;
			out_ph_q <= ph_q;
		end
	end

	assign res.valid = res_valid_q;
	assign res.applied_enable_mask = out_mask_q[0];
	assign res.applied_primary_bypass = out_mask_q[1];
	assign res.applied_sfx_bypass = out_mask_q[2];
	assign res.applied_noise_source = out_mask_q[3];
	assign res.dac_gain = out_gain_q;
	assign res.gain_write = out_wr_q;
	assign res.soft_mute_write = out_smw_q;
	assign res.soft_mute_value = out_smv_q;
	assign res.phase = out_ph_q;

endmodule
